@@ design/dtm_tpg_pkg.sv @@
`timescale 1ns / 1ps

package dtm_tpg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LEN,
    ST_PAY
  } state_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_BAD_TYPE = 2'd2
  } err_t;

  localparam logic [7:0] TYPE_PRBS9 = 8'd0;
  localparam logic [7:0] TYPE_0F    = 8'd1;
  localparam logic [7:0] TYPE_55    = 8'd2;
  localparam logic [7:0] TYPE_FF    = 8'd4;
  localparam logic [7:0] TYPE_00    = 8'd5;
  localparam logic [7:0] TYPE_F0    = 8'd6;
  localparam logic [7:0] TYPE_AA    = 8'd7;

  localparam logic [8:0] PRBS9_SEED   = 9'h1FF;
  localparam logic [8:0] HEADER_BYTES = 9'd2;
  localparam logic [6:0] CFG_RESET    = 7'd64;

  typedef struct packed {
    logic [7:0] data;
    logic [8:0] state;
  } prbs_step_t;

  // Recognized payload kinds.
  function automatic logic type_valid(input logic [7:0] t);
    case (t)
      TYPE_PRBS9, TYPE_0F, TYPE_55, TYPE_FF, TYPE_00, TYPE_F0, TYPE_AA: type_valid = 1'b1;
      default: type_valid = 1'b0;
    endcase
  endfunction

  // Constant fill byte of the pattern types.
  function automatic logic [7:0] fill_byte(input logic [7:0] t);
    case (t)
      TYPE_0F: fill_byte = 8'h0F;
      TYPE_55: fill_byte = 8'h55;
      TYPE_FF: fill_byte = 8'hFF;
      TYPE_F0: fill_byte = 8'hF0;
      TYPE_AA: fill_byte = 8'hAA;
      default: fill_byte = 8'h00;
    endcase
  endfunction

  // Eight LFSR steps, output bits packed MSB first.
  function automatic prbs_step_t prbs9_byte(input logic [8:0] s);
    logic [8:0] st;
    logic [7:0] b;
    prbs_step_t r;
    st = s;
    b  = 8'h00;
    for (int i = 0; i < 8; i++) begin
      b  = {b[6:0], st[0]};
      st = {st[0] ^ st[4], st[8:1]};
    end
    r.data  = b;
    r.state = st;
    prbs9_byte = r;
  endfunction

endpackage

@@ design/dtm_test_packet_generator.sv @@
`timescale 1ns / 1ps

// Direct-test-mode test packet generator. Each input item (packet_type,
// payload_length) yields a packet, one byte per result item: the type byte,
// the length byte, then payload_length payload bytes, with last set on the
// final one. Type 0 gives a PRBS9 payload (LFSR restarted at 0x1FF for every
// request, bits packed MSB first); types 1, 2, 4, 5, 6, 7 repeat 0x0F, 0x55,
// 0xFF, 0x00, 0xF0, 0xAA. A request whose length plus two header bytes exceeds
// the smaller of max_packet_len and MAX_PACKET gives one error item (code 1);
// otherwise an unknown type gives one error item (code 2). Error items carry
// data 0 and last 1. Steps: accept, check plus type byte, length byte,
// then one payload byte a cycle while the output is not stalled, from the
// shared byte-wide LFSR stepper; an error item ends at the check step. No
// new item is taken before the block is back in idle, but the next item is
// taken while the final result still waits in the output register. The user
// must write max_packet_len through cfg_wr_en / cfg_wr_data only while the
// block is idle (the block itself does not enforce this); it resets to 64.
module dtm_test_packet_generator
  import dtm_tpg_pkg::*;
#(
  parameter int MAX_PACKET = 64
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_packet_type,
  input  logic [7:0] in_payload_length,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_last,
  output logic [1:0] out_error_code,

  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  localparam logic [6:0] MaxPktC = 7'(MAX_PACKET);

  state_t     state_r, state_nxt;
  logic [6:0] max_len_r;
  logic [7:0] type_r, type_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [8:0] lfsr_r, lfsr_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] out_err_r, out_err_nxt;

  logic       slot_free;
  logic       in_acc;
  logic [6:0] limit;
  logic       overflow;
  logic       bad_type;
  prbs_step_t prbs;
  logic [7:0] pay_byte;

  // Output register can take a new item when empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // Effective packet limit and the request checks.
  assign limit    = (max_len_r > MaxPktC) ? MaxPktC : max_len_r;
  assign overflow = ({1'b0, len_r} + HEADER_BYTES) > {2'b00, limit};
  assign bad_type = !type_valid(type_r);

  // Shared stepper: one PRBS9 byte per use.
  assign prbs     = prbs9_byte(lfsr_r);
  assign pay_byte = (type_r == TYPE_PRBS9) ? prbs.data : fill_byte(type_r);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (slot_free) state_nxt = (overflow || bad_type) ? ST_IDLE : ST_LEN;
      end
      ST_LEN: begin
        if (slot_free) state_nxt = (len_r == 8'd0) ? ST_IDLE : ST_PAY;
      end
      ST_PAY: begin
        if (slot_free && cnt_r == 8'd1) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register loads.
  always_comb begin
    type_nxt      = type_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    lfsr_nxt      = lfsr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      ST_IDLE: begin
        // Capture the request and restart the LFSR.
        if (in_acc) begin
          type_nxt = in_packet_type;
          len_nxt  = in_payload_length;
          cnt_nxt  = in_payload_length;
          lfsr_nxt = PRBS9_SEED;
        end
      end
      ST_CHECK: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (overflow) begin
            out_data_nxt = 8'h00;
            out_last_nxt = 1'b1;
            out_err_nxt  = ERR_OVERFLOW;
          end else if (bad_type) begin
            out_data_nxt = 8'h00;
            out_last_nxt = 1'b1;
            out_err_nxt  = ERR_BAD_TYPE;
          end else begin
            out_data_nxt = type_r;
            out_last_nxt = 1'b0;
            out_err_nxt  = ERR_OK;
          end
        end
      end
      ST_LEN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = len_r;
          out_last_nxt  = (len_r == 8'd0);
          out_err_nxt   = ERR_OK;
        end
      end
      ST_PAY: begin
        // Emit one payload byte and advance the LFSR.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pay_byte;
          out_last_nxt  = (cnt_r == 8'd1);
          out_err_nxt   = ERR_OK;
          cnt_nxt       = cnt_r - 8'd1;
          lfsr_nxt      = prbs.state;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_len_r   <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    type_r     <= type_nxt;
    len_r      <= len_nxt;
    cnt_r      <= cnt_nxt;
    lfsr_r     <= lfsr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_data_r;
  assign out_last       = out_last_r;
  assign out_error_code = out_err_r;

`ifndef NO_ASSERTIONS
  // An error item always ends its request and carries a zero byte.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_err_r != ERR_OK) |-> out_last_r && (out_data_r == 8'h00))
    else $error("error item without last or with nonzero data");

  // The payload counter never runs out while bytes remain to send.
  a_pay_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAY) |-> (cnt_r != 8'd0))
    else $error("payload state with zero count");

  // An accepted request goes straight to the check step.
  a_acc_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CHECK))
    else $error("accepted item did not enter check");

  // Leaving the payload state coincides with loading the last byte.
  a_pay_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAY) && (state_nxt == ST_IDLE) |=> out_valid_r && out_last_r)
    else $error("payload ended without a last item");
`endif

endmodule
